>>> design/rtc_time_decode_assert.svh
// ----------------------------------------------------------------------------
// RTC time decode assertion macros
// Shorthand for the concurrent checks of the RTC time decoder.
// ----------------------------------------------------------------------------
`ifndef RTC_TIME_DECODE_ASSERT_SVH
`define RTC_TIME_DECODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rtc_td_pkg.sv
// ----------------------------------------------------------------------------
// RTC time decode package
// Shared types, register codes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package rtc_td_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_WANT_24   = 2'd0;
  localparam logic [1:0] REG_DST       = 2'd1;
  localparam logic [1:0] REG_HAS_CEN   = 2'd2;
  localparam logic [1:0] REG_BASE_YEAR = 2'd3;

  localparam logic [13:0] BASE_YEAR_RST = 14'd2000;

  // Status B bits.
  localparam int unsigned SB_BINARY_BIT = 2;
  localparam int unsigned SB_24H_BIT    = 1;

  localparam logic [7:0]  NO_CENTURY    = 8'hFF;
  localparam logic [2:0]  WEEKDAY_BAD   = 3'd7;
  localparam logic [6:0]  HOUR_TWELVE   = 7'd12;
  localparam logic [7:0]  HOUR_LAST     = 8'd23;

  // ceil(2^23 / 100): exact floor(y / 100) for every 16-bit y.
  localparam logic [16:0] Div100Mul     = 17'd83887;
  localparam int unsigned Div100Shift   = 23;

  typedef struct packed {
    logic        want_24_hour;
    logic        daylight_saving;
    logic        has_century;
    logic [13:0] base_year;
  } cfg_t;

  typedef struct packed {
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic [7:0] raw_century;
    logic [7:0] status_b;
  } raw_t;

  typedef struct packed {
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] year;
    logic [7:0]  century;
  } date_t;

  // Handed from the decoder to the weekday pipeline.
  typedef struct packed {
    logic [15:0] wd_year;
    logic        mon_ok;
    logic [8:0]  off_day;
  } wd_req_t;

  // Each nibble weighted as it stands: low + 10 * high, wrapped to 8 bits.
  function automatic logic [7:0] bcd8(input logic [7:0] v);
    return {4'b0, v[3:0]} + {1'b0, v[7:4], 3'b0} + {3'b0, v[7:4], 1'b0};
  endfunction

  // Value below 192, reduced modulo 24 by three conditional subtractions.
  function automatic logic [7:0] mod24(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd96) t = t - 8'd96;
    if (t >= 8'd48) t = t - 8'd48;
    if (t >= 8'd24) t = t - 8'd24;
    return t;
  endfunction

  // Month offsets of the weekday formula, indexed by month - 1.
  function automatic logic [2:0] dow_offset(input logic [3:0] idx);
    logic [2:0] r;
    case (idx)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd5;
      4'd4:    r = 3'd0;
      4'd5:    r = 3'd3;
      4'd6:    r = 3'd5;
      4'd7:    r = 3'd1;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd6;
      4'd10:   r = 3'd2;
      4'd11:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/rtc_td_cfg.sv
// ----------------------------------------------------------------------------
// RTC time decode configuration registers
// APB-style register file holding the four decode settings.
// ----------------------------------------------------------------------------
module rtc_td_cfg
  import rtc_td_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_WANT_24:   cfg_nxt.want_24_hour    = pwdata[0];
        REG_DST:       cfg_nxt.daylight_saving = pwdata[0];
        REG_HAS_CEN:   cfg_nxt.has_century     = pwdata[0];
        REG_BASE_YEAR: cfg_nxt.base_year       = pwdata[13:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.want_24_hour    <= 1'b1;
      cfg_r.daylight_saving <= 1'b0;
      cfg_r.has_century     <= 1'b0;
      cfg_r.base_year       <= BASE_YEAR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WANT_24:   prdata = {31'b0, cfg_r.want_24_hour};
      REG_DST:       prdata = {31'b0, cfg_r.daylight_saving};
      REG_HAS_CEN:   prdata = {31'b0, cfg_r.has_century};
      REG_BASE_YEAR: prdata = {18'b0, cfg_r.base_year};
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> design/rtc_td_decode.sv
// ----------------------------------------------------------------------------
// RTC time decode field stage
// BCD conversion, hour format handling, full year and weekday set-up.
// ----------------------------------------------------------------------------
module rtc_td_decode
  import rtc_td_pkg::*;
(
  input  logic    clk,
  input  raw_t    raw,
  input  cfg_t    cfg,
  output date_t   date,
  output wd_req_t wd_req
);

  date_t      date_r;
  date_t      date_nxt;
  wd_req_t    wd_req_r;
  wd_req_t    wd_req_nxt;
  logic       binary;
  logic [7:0] hr_dec;
  logic [6:0] h7;
  logic [7:0] hr_conv;
  logic [7:0] yr;
  logic [15:0] cen_x100;

  assign binary = raw.status_b[SB_BINARY_BIT];

  // The hour keeps bit 7 as the PM flag; only bits 6..4 carry its tens.
  assign hr_dec = binary ? raw.raw_hour :
                  {raw.raw_hour[7],
                   7'({3'b0, raw.raw_hour[3:0]} + {1'b0, raw.raw_hour[6:4], 3'b0} +
                      {3'b0, raw.raw_hour[6:4], 1'b0})};
  assign h7 = hr_dec[6:0];

  always_comb begin
    hr_conv = hr_dec;
    if (cfg.want_24_hour && !raw.status_b[SB_24H_BIT]) begin
      if (hr_dec[7]) begin
        hr_conv = mod24(((h7 == HOUR_TWELVE) ? 8'd0 : {1'b0, h7}) + 8'd12);
      end else if (h7 == HOUR_TWELVE) begin
        hr_conv = 8'd0;
      end
    end
    if (cfg.daylight_saving && cfg.want_24_hour) begin
      hr_conv = (hr_conv == HOUR_LAST) ? 8'd0 : hr_conv + 8'd1;
    end
  end

  assign yr = binary ? raw.raw_year : bcd8(raw.raw_year);

  always_comb begin
    date_nxt.second = binary ? raw.raw_second : bcd8(raw.raw_second);
    date_nxt.minute = binary ? raw.raw_minute : bcd8(raw.raw_minute);
    date_nxt.hour   = hr_conv;
    date_nxt.day    = binary ? raw.raw_day    : bcd8(raw.raw_day);
    date_nxt.month  = binary ? raw.raw_month  : bcd8(raw.raw_month);
    if (cfg.has_century) begin
      date_nxt.century = binary ? raw.raw_century : bcd8(raw.raw_century);
    end else begin
      date_nxt.century = NO_CENTURY;
    end
    // century * 100 as shifted partial sums (64 + 32 + 4).
    cen_x100 = {2'b0, date_nxt.century, 6'b0} + {3'b0, date_nxt.century, 5'b0} +
               {6'b0, date_nxt.century, 2'b0};
    if (cfg.has_century) begin
      date_nxt.year = {8'b0, yr} + cen_x100;
    end else begin
      date_nxt.year = {8'b0, yr} + {2'b0, cfg.base_year};
    end
  end

  // January and February count as months of the previous year.
  always_comb begin
    wd_req_nxt.mon_ok  = (date_nxt.month >= 8'd1) && (date_nxt.month <= 8'd12);
    wd_req_nxt.wd_year = (date_nxt.month < 8'd3) ? date_nxt.year - 16'd1 : date_nxt.year;
    wd_req_nxt.off_day = {6'b0, dow_offset(date_nxt.month[3:0] - 4'd1)} +
                         {1'b0, date_nxt.day};
  end

  always_ff @(posedge clk) begin
    date_r   <= date_nxt;
    wd_req_r <= wd_req_nxt;
  end

  assign date   = date_r;
  assign wd_req = wd_req_r;

endmodule

>>> design/rtc_td_weekday.sv
// ----------------------------------------------------------------------------
// RTC time decode weekday pipeline
// Two-stage day-of-week: divide by 100 by reciprocal, then sum modulo 7.
// ----------------------------------------------------------------------------
module rtc_td_weekday
  import rtc_td_pkg::*;
(
  input  logic       clk,
  input  wd_req_t    wd_req,
  output logic [2:0] weekday
);

  logic [32:0] prod;
  logic [15:0] y_r;
  logic [9:0]  q100_r;
  logic        ok_r;
  logic [8:0]  off_r;
  logic [16:0] sum;
  logic [17:0] sum_pad;
  logic [5:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  rem7;
  logic [2:0]  wd_r;
  logic [2:0]  wd_nxt;

  assign prod = {17'b0, wd_req.wd_year} * {16'b0, Div100Mul};

  always_ff @(posedge clk) begin
    y_r    <= wd_req.wd_year;
    q100_r <= prod[Div100Shift+9:Div100Shift];
    ok_r   <= wd_req.mon_ok;
    off_r  <= wd_req.off_day;
  end

  // y + y/4 - y/100 + y/400 + offset + day; y/400 is (y/100)/4.
  assign sum = {1'b0, y_r} + {3'b0, y_r[15:2]} + {9'b0, q100_r[9:2]} +
               {8'b0, off_r} - {7'b0, q100_r};

  // Eight is one modulo seven, so octal digits fold together.
  assign sum_pad = {1'b0, sum};
  assign fold1 = {3'b0, sum_pad[2:0]}   + {3'b0, sum_pad[5:3]}   +
                 {3'b0, sum_pad[8:6]}   + {3'b0, sum_pad[11:9]}  +
                 {3'b0, sum_pad[14:12]} + {3'b0, sum_pad[17:15]};
  assign fold2 = {1'b0, fold1[5:3]} + {1'b0, fold1[2:0]};
  assign rem7  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  assign wd_nxt = ok_r ? rem7 : WEEKDAY_BAD;

  always_ff @(posedge clk) begin
    wd_r <= wd_nxt;
  end

  assign weekday = wd_r;

endmodule

>>> design/rtc_time_decode.sv
// ----------------------------------------------------------------------------
// RTC time decode top level
// Decodes one snapshot of real-time-clock registers into date and time.
// ----------------------------------------------------------------------------
// A word is taken at every rising edge where start is high; busy is never
// raised, so a new word may follow in every cycle. Each word gives exactly one
// result, shown on the out_ ports with out_valid high for a single cycle once
// it has passed the input register, field decode, the reciprocal divide by
// 100, and the modulo-7 sum with the result register. The receiver cannot
// hold results off and must take each word in its strobe cycle. The
// configuration registers are read by the field decode stage, so they
// should only be written while no word is in flight.
// ----------------------------------------------------------------------------
`include "rtc_time_decode_assert.svh"

module rtc_time_decode
  import rtc_td_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                start,
  output logic                busy,
  input  logic [7:0]          in_raw_second,
  input  logic [7:0]          in_raw_minute,
  input  logic [7:0]          in_raw_hour,
  input  logic [7:0]          in_raw_day,
  input  logic [7:0]          in_raw_month,
  input  logic [7:0]          in_raw_year,
  input  logic [7:0]          in_raw_century,
  input  logic [7:0]          in_status_b,

  output logic                out_valid,
  output logic [7:0]          out_second,
  output logic [7:0]          out_minute,
  output logic [7:0]          out_hour,
  output logic [7:0]          out_day,
  output logic [7:0]          out_month,
  output logic [15:0]         out_year,
  output logic [7:0]          out_century,
  output logic [2:0]          out_weekday,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  raw_t    raw_r;
  raw_t    raw_nxt;
  date_t   date_s1;
  wd_req_t wd_req_s1;
  date_t   date_s2_r;
  date_t   date_out_r;
  logic    accept;
  logic    v0_r;
  logic    v1_r;
  logic    v2_r;
  logic    v3_r;

  // Every stage advances each cycle, so the block never stalls its source.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rtc_td_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    raw_nxt.raw_second  = in_raw_second;
    raw_nxt.raw_minute  = in_raw_minute;
    raw_nxt.raw_hour    = in_raw_hour;
    raw_nxt.raw_day     = in_raw_day;
    raw_nxt.raw_month   = in_raw_month;
    raw_nxt.raw_year    = in_raw_year;
    raw_nxt.raw_century = in_raw_century;
    raw_nxt.status_b    = in_status_b;
  end

  // Payload registers load freely; the valid chain marks real words.
  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    date_s2_r  <= date_s1;
    date_out_r <= date_s2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  rtc_td_decode u_decode (
    .clk    (clk),
    .raw    (raw_r),
    .cfg    (cfg),
    .date   (date_s1),
    .wd_req (wd_req_s1)
  );

  rtc_td_weekday u_weekday (
    .clk     (clk),
    .wd_req  (wd_req_s1),
    .weekday (out_weekday)
  );

  assign out_valid   = v3_r;
  assign out_second  = date_out_r.second;
  assign out_minute  = date_out_r.minute;
  assign out_hour    = date_out_r.hour;
  assign out_day     = date_out_r.day;
  assign out_month   = date_out_r.month;
  assign out_year    = date_out_r.year;
  assign out_century = date_out_r.century;

  // Every accepted word comes out after the fixed pipeline depth.
  `RTD_ASSERT_NOW(a_accept_to_result, clk, rst_n, accept, ##4 out_valid, "result strobe missing")

  // No strobe appears without an accepted word to match it.
  `RTD_ASSERT_NOW(a_result_has_source, clk, rst_n, out_valid, $past(accept, 4), "spurious result")

  // Weekday seven marks exactly the months outside one to twelve.
  `RTD_ASSERT_NOW(a_bad_month_weekday, clk, rst_n, out_valid,
    (out_weekday == WEEKDAY_BAD) == (out_month == 8'd0 || out_month > 8'd12),
    "weekday and month validity disagree")

  // Without a century register the century field reads as all ones.
  `RTD_ASSERT_NEXT(a_no_century, clk, rst_n, v2_r && !u_cfg.cfg.has_century,
    out_century == NO_CENTURY, "century not flagged absent")

endmodule

>>> tb/rtc_time_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC time decode checker
// Watches the input, result and register channels of the decoder, keeps its
// own copy of the settings, works out each decoded date and compares it with
// the result words in order.
// ----------------------------------------------------------------------------
module rtc_time_decode_checker
  import rtc_td_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                start,
  input  logic                busy,
  input  logic [7:0]          in_raw_second,
  input  logic [7:0]          in_raw_minute,
  input  logic [7:0]          in_raw_hour,
  input  logic [7:0]          in_raw_day,
  input  logic [7:0]          in_raw_month,
  input  logic [7:0]          in_raw_year,
  input  logic [7:0]          in_raw_century,
  input  logic [7:0]          in_status_b,

  input  logic                out_valid,
  input  logic [7:0]          out_second,
  input  logic [7:0]          out_minute,
  input  logic [7:0]          out_hour,
  input  logic [7:0]          out_day,
  input  logic [7:0]          out_month,
  input  logic [15:0]         out_year,
  input  logic [7:0]          out_century,
  input  logic [2:0]          out_weekday,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic                pready,

  output int                  n_fail,
  output int                  n_pending
);

  typedef struct packed {
    date_t      date;
    logic [2:0] weekday;
  } decoded_t;

  // Month offsets of the weekday sum, four bits each, January in the low bits.
  localparam logic [47:0] MONTH_KEY = {4'd4, 4'd2, 4'd6, 4'd4, 4'd1, 4'd5,
                                       4'd3, 4'd0, 4'd5, 4'd2, 4'd3, 4'd0};

  cfg_t     settings;
  raw_t     snapshot;
  decoded_t oldest;
  decoded_t pending_dates[$];
  int       mismatches = 0;

  assign snapshot = {in_raw_second, in_raw_minute, in_raw_hour, in_raw_day,
                     in_raw_month, in_raw_year, in_raw_century, in_status_b};

  function automatic int unsigned from_bcd(input logic [7:0] v);
    int unsigned x;
    x = 32'(v);
    return (x % 16 + (x / 16) * 10) % 256;
  endfunction

  function automatic decoded_t decode_snapshot(input raw_t r, input cfg_t c);
    decoded_t    d;
    int unsigned sec, mnt, hr, dom, mon, yr, cen, full_year, h, y, wd;
    sec = 32'(r.raw_second);
    mnt = 32'(r.raw_minute);
    hr  = 32'(r.raw_hour);
    dom = 32'(r.raw_day);
    mon = 32'(r.raw_month);
    yr  = 32'(r.raw_year);
    cen = c.has_century ? 32'(r.raw_century) : 32'hFF;
    if (!r.status_b[SB_BINARY_BIT]) begin
      sec = from_bcd(r.raw_second);
      mnt = from_bcd(r.raw_minute);
      dom = from_bcd(r.raw_day);
      mon = from_bcd(r.raw_month);
      yr  = from_bcd(r.raw_year);
      // Only bits 6..4 count as the hour's tens; bit 7 rides along as PM.
      hr  = (hr % 16) + ((hr / 16) % 8) * 10 + (hr & 32'h80);
      if (c.has_century) cen = from_bcd(r.raw_century);
    end
    if (c.want_24_hour && !r.status_b[SB_24H_BIT]) begin
      h = hr % 128;
      if ((hr & 32'h80) != 0) hr = ((h == 12 ? 0 : h) + 12) % 24;
      else if (h == 12) hr = 0;
    end
    if (c.daylight_saving && c.want_24_hour) hr = (hr == 23) ? 0 : (hr + 1) % 256;
    full_year = ((c.has_century ? cen * 100 : 32'(c.base_year)) + yr) % 65536;
    if (mon < 1 || mon > 12) begin
      wd = 7;
    end else begin
      y = (mon < 3) ? (full_year + 65535) % 65536 : full_year;
      wd = (y + y / 4 - y / 100 + y / 400 + MONTH_KEY[4 * (mon - 1) +: 4] + dom) % 7;
    end
    d.date.second  = sec[7:0];
    d.date.minute  = mnt[7:0];
    d.date.hour    = hr[7:0];
    d.date.day     = dom[7:0];
    d.date.month   = mon[7:0];
    d.date.year    = full_year[15:0];
    d.date.century = cen[7:0];
    d.weekday      = wd[2:0];
    return d;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_dates.delete();
      settings.want_24_hour    = 1'b1;
      settings.daylight_saving = 1'b0;
      settings.has_century     = 1'b0;
      settings.base_year       = BASE_YEAR_RST;
      n_pending <= 0;
    end else begin
      if (out_valid) begin
        if (pending_dates.size() == 0) begin
          $display("%0t ns: result word with no expectation waiting (hour %0d, year %0d)",
                   $time, out_hour, out_year);
          mismatches++;
        end else begin
          oldest = pending_dates.pop_front();
          check_field("second", oldest.date.second, out_second);
          check_field("minute", oldest.date.minute, out_minute);
          check_field("hour", oldest.date.hour, out_hour);
          check_field("day", oldest.date.day, out_day);
          check_field("month", oldest.date.month, out_month);
          check_field("year", oldest.date.year, out_year);
          check_field("century", oldest.date.century, out_century);
          check_field("weekday", oldest.weekday, out_weekday);
        end
      end
      if (start && !busy) pending_dates.push_back(decode_snapshot(snapshot, settings));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WANT_24:   settings.want_24_hour    = pwdata[0];
          REG_DST:       settings.daylight_saving = pwdata[0];
          REG_HAS_CEN:   settings.has_century     = pwdata[0];
          REG_BASE_YEAR: settings.base_year       = pwdata[13:0];
          default: ;
        endcase
      end
      n_pending <= pending_dates.size();
    end
    n_fail <= mismatches;
  end

endmodule

>>> tb/tb_rtc_time_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC time decode testbench
// Drives register snapshots into the decoder, first a directed set covering
// BCD and binary readings, 12/24-hour conversion, daylight saving, century
// and base year, invalid months and early-year weekdays, then random phases
// with different settings and sender gaps. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_rtc_time_decode;
  import rtc_td_pkg::*;

  // Delay from an accepted word to its result, used for the quiet waits.
  localparam int LATENCY         = 4;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 125;
  localparam int DRAIN_LIMIT     = 1000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;

  logic                start = 1'b0;
  logic                busy;
  logic [7:0]          in_raw_second = '0;
  logic [7:0]          in_raw_minute = '0;
  logic [7:0]          in_raw_hour = '0;
  logic [7:0]          in_raw_day = '0;
  logic [7:0]          in_raw_month = '0;
  logic [7:0]          in_raw_year = '0;
  logic [7:0]          in_raw_century = '0;
  logic [7:0]          in_status_b = '0;

  logic                out_valid;
  logic [7:0]          out_second;
  logic [7:0]          out_minute;
  logic [7:0]          out_hour;
  logic [7:0]          out_day;
  logic [7:0]          out_month;
  logic [15:0]         out_year;
  logic [7:0]          out_century;
  logic [2:0]          out_weekday;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int                  n_fail;
  int                  n_pending;

  rtc_time_decode i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_raw_second  (in_raw_second),
    .in_raw_minute  (in_raw_minute),
    .in_raw_hour    (in_raw_hour),
    .in_raw_day     (in_raw_day),
    .in_raw_month   (in_raw_month),
    .in_raw_year    (in_raw_year),
    .in_raw_century (in_raw_century),
    .in_status_b    (in_status_b),
    .out_valid      (out_valid),
    .out_second     (out_second),
    .out_minute     (out_minute),
    .out_hour       (out_hour),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_century    (out_century),
    .out_weekday    (out_weekday),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  rtc_time_decode_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_raw_second  (in_raw_second),
    .in_raw_minute  (in_raw_minute),
    .in_raw_hour    (in_raw_hour),
    .in_raw_day     (in_raw_day),
    .in_raw_month   (in_raw_month),
    .in_raw_year    (in_raw_year),
    .in_raw_century (in_raw_century),
    .in_status_b    (in_status_b),
    .out_valid      (out_valid),
    .out_second     (out_second),
    .out_minute     (out_minute),
    .out_hour       (out_hour),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_century    (out_century),
    .out_weekday    (out_weekday),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .n_fail         (n_fail),
    .n_pending      (n_pending)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // An idle step with start low. The snapshot ports carry random noise so that
  // the block is seen to ignore them while no word is offered.
  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    {in_raw_second, in_raw_minute, in_raw_hour, in_raw_day} <= $urandom;
    {in_raw_month, in_raw_year, in_raw_century, in_status_b} <= $urandom;
  endtask

  // Offers one word after a random gap and holds it until the block takes it.
  // The gap loop continues with the given chance in percent, so that about
  // that share of the cycles is idle. Start is assigned once per falling edge,
  // so back-to-back words keep it high without a glitch.
  task automatic send_snapshot(input raw_t w, input int idle_pct);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    @(negedge clk);
    start          <= 1'b1;
    in_raw_second  <= w.raw_second;
    in_raw_minute  <= w.raw_minute;
    in_raw_hour    <= w.raw_hour;
    in_raw_day     <= w.raw_day;
    in_raw_month   <= w.raw_month;
    in_raw_year    <= w.raw_year;
    in_raw_century <= w.raw_century;
    in_status_b    <= w.status_b;
    do @(posedge clk); while (busy);
  endtask

  // One register write: setup cycle, then access cycle until pready. Bits
  // above the register's width carry noise; the block must drop them.
  task automatic write_reg(input logic [1:0] idx, input int unsigned value,
                           input int bits);
    logic [31:0] keep;
    keep = (32'h1 << bits) - 1;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~keep) | (value & keep);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Settings change only with the pipeline empty: start goes low, every
  // expected word must have arrived, and a settle wait passes on top.
  task automatic set_config(input logic want_24, input logic dst, input logic has_cen,
                            input logic [13:0] base);
    idle_cycle();
    while (n_pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    write_reg(REG_WANT_24, {31'b0, want_24}, 1);
    write_reg(REG_DST, {31'b0, dst}, 1);
    write_reg(REG_HAS_CEN, {31'b0, has_cen}, 1);
    write_reg(REG_BASE_YEAR, {18'b0, base}, 14);
  endtask

  function automatic logic [7:0] encode(input int unsigned v, input logic binary);
    return binary ? v[7:0] : 8'(v % 10) | 8'((v / 10) << 4);
  endfunction

  // Mostly well-formed snapshots (valid BCD or binary values, real months and
  // hours in the form the status byte claims), the rest pure noise.
  function automatic raw_t random_snapshot();
    raw_t s;
    logic binary, h24;
    if ($urandom_range(99) < 25) begin
      s = {$urandom, $urandom};
      return s;
    end
    binary = 1'($urandom_range(1));
    h24    = 1'($urandom_range(1));
    s.status_b = 8'($urandom);
    s.status_b[SB_BINARY_BIT] = binary;
    s.status_b[SB_24H_BIT]    = h24;
    s.raw_second  = encode($urandom_range(59), binary);
    s.raw_minute  = encode($urandom_range(59), binary);
    s.raw_day     = encode($urandom_range(31, 1), binary);
    s.raw_month   = encode($urandom_range(12, 1), binary);
    s.raw_year    = encode($urandom_range(99), binary);
    s.raw_century = encode($urandom_range(99), binary);
    if (h24) begin
      s.raw_hour = encode($urandom_range(23), binary);
    end else begin
      s.raw_hour = encode($urandom_range(12, 1), binary);
      s.raw_hour[7] = 1'($urandom_range(1));
    end
    return s;
  endfunction

  initial begin
    logic [13:0] base;
    int          idle_pct;
    int          waited;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Each literal lists, from the top byte down: second,
    // minute, hour, day, month, year, century, status B.
    // Reset settings: 24-hour output, no daylight saving, base year 2000.
    send_snapshot(64'h59_59_23_31_12_99_20_02, 0); // BCD maximum, device 24-hour
    send_snapshot(64'hFF_FF_FF_FF_FF_FF_FF_00, 0); // non-decimal BCD digits, PM
    send_snapshot(64'h00_00_12_00_00_00_00_00, 0); // 12 AM, month zero
    send_snapshot(64'h00_00_92_01_13_00_00_00, 0); // 12 PM, month thirteen
    send_snapshot(64'h30_15_81_01_01_24_00_00, 0); // 1 PM, January
    send_snapshot(64'h45_30_11_29_02_24_00_00, 0); // 11 AM, February
    send_snapshot(64'h3B_3B_8B_1F_03_63_00_04, 0); // binary 11 PM, March
    send_snapshot(64'h00_00_FF_01_0C_00_00_06, 0); // binary, device 24-hour
    send_snapshot(64'h00_00_00_00_00_00_00_04, 0); // binary zeros
    send_snapshot(64'hFF_FF_FF_FF_FF_FF_FF_FF, 0); // binary ones
    send_snapshot(64'hFF_FF_FF_FF_FF_FF_FF_FB, 0); // BCD with other status bits set

    // Conversion off: the hour stays as read, PM flag and all.
    set_config(1'b0, 1'b1, 1'b0, 14'd2000);
    send_snapshot(64'h00_00_92_15_06_10_00_00, 0);
    send_snapshot(64'h00_00_23_15_06_10_00_02, 0); // daylight saving has no effect

    // Daylight saving with 24-hour output.
    set_config(1'b1, 1'b1, 1'b0, 14'd2000);
    send_snapshot(64'h00_00_23_31_12_99_00_02, 0); // 23 wraps to 0
    send_snapshot(64'h00_00_91_31_12_99_00_00, 0); // 11 PM, then wrap
    send_snapshot(64'h00_00_12_01_01_00_00_00, 0); // 12 AM becomes 1
    send_snapshot(64'h00_00_FF_01_01_00_00_06, 0); // 255 wraps at 8 bits

    // Century register, base year at its lowest.
    set_config(1'b1, 1'b0, 1'b1, 14'd0);
    send_snapshot(64'h00_00_08_29_02_24_20_00, 0);
    send_snapshot(64'h00_00_08_1F_0C_FF_FF_04, 0); // century and year at their largest
    send_snapshot(64'h00_00_08_01_01_00_00_04, 0); // year zero in January

    set_config(1'b1, 1'b0, 1'b0, 14'd0);
    send_snapshot(64'h00_00_08_01_02_00_55_04, 0); // year zero, century ignored
    set_config(1'b1, 1'b0, 1'b0, 14'h3FFF);
    send_snapshot(64'h00_00_08_01_0C_FF_00_04, 0); // largest base year

    // Random phases. The receiver cannot hold results off, so only the
    // sender's gaps vary: none, 73 in a hundred, 24 in a hundred.
    for (int k = 0; k < PHASES; k++) begin
      case ($urandom_range(3))
        0:       base = 14'd0;
        1:       base = 14'd9900;
        2:       base = 14'h3FFF;
        default: base = 14'($urandom_range(9900));
      endcase
      if (k == 0) base = 14'd9900;
      set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 base);
      case (k % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 73;
        default: idle_pct = 24;
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_snapshot(random_snapshot(), idle_pct);
    end

    // Drain: every expected word must arrive, then a quiet wait catches
    // any stray result.
    idle_cycle();
    waited = 0;
    while (n_pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
